FILE: sv/tlst_pkg.sv
package tlst_pkg;

  localparam int TIME_W      = 64;
  localparam int PAY_W       = 32;
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int FIELD_IDX_W = 11;

  localparam int IN_TDATA_W  = 96;
  localparam int IN_PAY_LSB  = 64;
  localparam int OUT_TDATA_W = 120;
  localparam int OUT_TUSER_W = 3;

  localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SEEK      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NEXT      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PREV      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_LAST = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ORDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd3;

  typedef enum logic [2:0] {
    ADDR_PROBE,
    ADDR_LO,
    ADDR_LO_M1,
    ADDR_CUR,
    ADDR_CUR_M1
  } addr_sel_t;

  typedef enum logic [3:0] {
    RES_APPEND,
    RES_SEEK_OK,
    RES_SEEK_NONE,
    RES_NEXT,
    RES_PREV,
    RES_AT_END,
    RES_LAST,
    RES_CLEAR,
    RES_NONE
  } res_sel_t;

  typedef struct packed {
    logic      capture;
    logic      seek_init;
    logic      target_load;
    logic      search;
    logic      step;
    logic      rd_en;
    addr_sel_t addr_sel;
    logic      finish;
    res_sel_t  res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              cur_at_end;
    logic              prev_blocked;
    logic              search_more;
    logic              lo_zero;
    logic              strict;
    logic              out_free;
  } dp_stat_t;

endpackage

FILE: sv/tlst_ram.sv
module tlst_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/tlst_ctrl.sv
module tlst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  tlst_pkg::dp_stat_t stat,
  output tlst_pkg::dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_PROBE  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_TLOAD  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  tlst_pkg::res_sel_t res_r, res_nxt;

  always_comb begin
    state_nxt    = state_r;
    res_nxt      = res_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.addr_sel = tlst_pkg::ADDR_PROBE;
    cmd.res_sel  = res_r;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (stat.kind)
          tlst_pkg::KIND_APPEND:    res_nxt = tlst_pkg::RES_APPEND;
          tlst_pkg::KIND_READ_LAST: res_nxt = tlst_pkg::RES_LAST;
          tlst_pkg::KIND_CLEAR:     res_nxt = tlst_pkg::RES_CLEAR;
          tlst_pkg::KIND_NEXT: begin
            if (stat.cur_at_end) begin
              res_nxt = tlst_pkg::RES_AT_END;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.addr_sel = tlst_pkg::ADDR_CUR;
              res_nxt      = tlst_pkg::RES_NEXT;
            end
          end
          tlst_pkg::KIND_PREV: begin
            if (stat.prev_blocked) begin
              res_nxt = tlst_pkg::RES_AT_END;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.addr_sel = tlst_pkg::ADDR_CUR_M1;
              res_nxt      = tlst_pkg::RES_PREV;
            end
          end
          tlst_pkg::KIND_SEEK: begin
            cmd.seek_init = 1'b1;
            state_nxt     = S_PROBE;
          end
          default: res_nxt = tlst_pkg::RES_NONE;
        endcase
      end
      S_PROBE, S_SCAN: begin
        cmd.search = 1'b1;
        cmd.step   = (state_r == S_SCAN);
        cmd.rd_en  = 1'b1;
        if (stat.search_more) begin
          cmd.addr_sel = tlst_pkg::ADDR_PROBE;
          state_nxt    = S_SCAN;
        end else if (stat.strict) begin
          cmd.addr_sel = tlst_pkg::ADDR_LO;
          res_nxt      = tlst_pkg::RES_SEEK_OK;
          state_nxt    = S_DONE;
        end else if (stat.lo_zero) begin
          cmd.rd_en = 1'b0;
          res_nxt   = tlst_pkg::RES_SEEK_NONE;
          state_nxt = S_DONE;
        end else begin
          cmd.addr_sel = tlst_pkg::ADDR_LO_M1;
          state_nxt    = S_TLOAD;
        end
      end
      S_TLOAD: begin
        cmd.target_load = 1'b1;
        state_nxt       = S_PROBE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= tlst_pkg::RES_NONE;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

FILE: sv/tlst_dp.sv
module tlst_dp #(
  parameter int DEPTH         = 1024,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tlst_pkg::dp_cmd_t                   cmd,
  output tlst_pkg::dp_stat_t                  stat,
  input  logic [tlst_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [tlst_pkg::KIND_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tlst_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [tlst_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PWE = (PAYLOAD_WIDTH < tlst_pkg::PAY_W) ? PAYLOAD_WIDTH : tlst_pkg::PAY_W;
  localparam int TW  = tlst_pkg::TIME_W;
  localparam int FW  = tlst_pkg::FIELD_IDX_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [CW-1:0] count_r, count_nxt, cursor_r, cursor_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic          strict_r, strict_nxt;
  logic [tlst_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [TW-1:0]  key_r, key_nxt, last_time_r, last_time_nxt;
  logic [PWE-1:0] pay_r, pay_nxt, last_pay_r, last_pay_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [tlst_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic                           out_more_r, out_more_nxt;
  logic [TW-1:0]                  out_time_r, out_time_nxt;
  logic [tlst_pkg::PAY_W-1:0]     out_pay_r, out_pay_nxt;
  logic [FW-1:0]                  out_idx_r, out_idx_nxt, out_cnt_r, out_cnt_nxt;

  logic           ram_we, left;
  logic [AW-1:0]  ram_raddr;
  logic [TW+PWE-1:0] ram_rdata;
  logic [TW-1:0]  rd_time;
  logic [PWE-1:0] rd_pay;
  logic [CW-1:0]  lo_step, hi_step, cur_lo, cur_hi, probe_mid, addr_full;

  tlst_ram #(.WIDTH(TW + PWE), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({pay_r, key_r}),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_time = ram_rdata[TW-1:0];
  assign rd_pay  = ram_rdata[TW +: PWE];

  assign left      = strict_r ? (rd_time < key_r) : (rd_time <= key_r);
  assign lo_step   = left ? (mid_r + CW'(1)) : lo_r;
  assign hi_step   = left ? hi_r : mid_r;
  assign cur_lo    = cmd.step ? lo_step : lo_r;
  assign cur_hi    = cmd.step ? hi_step : hi_r;
  assign probe_mid = cur_lo + ((cur_hi - cur_lo) >> 1);

  always_comb begin
    case (cmd.addr_sel)
      tlst_pkg::ADDR_PROBE:  addr_full = probe_mid;
      tlst_pkg::ADDR_LO:     addr_full = cur_lo;
      tlst_pkg::ADDR_LO_M1:  addr_full = cur_lo - CW'(1);
      tlst_pkg::ADDR_CUR:    addr_full = cursor_r;
      tlst_pkg::ADDR_CUR_M1: addr_full = cursor_r - CW'(1);
      default:               addr_full = cursor_r;
    endcase
  end

  assign ram_raddr = addr_full[AW-1:0];

  assign stat.kind         = kind_r;
  assign stat.cur_at_end   = (cursor_r >= count_r);
  assign stat.prev_blocked = (cursor_r == '0) || (cursor_r > count_r);
  assign stat.search_more  = (cur_lo < cur_hi);
  assign stat.lo_zero      = (cur_lo == '0);
  assign stat.strict       = strict_r;
  assign stat.out_free     = !out_valid_r || out_tready;

  always_comb begin
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    strict_nxt     = strict_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    last_time_nxt  = last_time_r;
    last_pay_nxt   = last_pay_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_more_nxt   = out_more_r;
    out_time_nxt   = out_time_r;
    out_pay_nxt    = out_pay_r;
    out_idx_nxt    = out_idx_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;

    if (cmd.capture) begin
      kind_nxt = in_tuser;
      key_nxt  = in_tdata[TW-1:0];
      pay_nxt  = in_tdata[tlst_pkg::IN_PAY_LSB +: PWE];
    end
    if (cmd.seek_init) begin
      strict_nxt = 1'b0;
      lo_nxt     = '0;
      hi_nxt     = count_r;
    end
    if (cmd.target_load) begin
      key_nxt    = rd_time;
      strict_nxt = 1'b1;
      lo_nxt     = '0;
      hi_nxt     = lo_r - CW'(1);
    end
    if (cmd.search) begin
      lo_nxt  = cur_lo;
      hi_nxt  = cur_hi;
      mid_nxt = probe_mid;
    end

    if (cmd.finish) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = tlst_pkg::ST_NONE;
      out_more_nxt   = 1'b0;
      out_time_nxt   = '0;
      out_pay_nxt    = '0;
      out_idx_nxt    = '0;
      case (cmd.res_sel)
        tlst_pkg::RES_APPEND: begin
          if (count_r == FULL_COUNT) begin
            out_status_nxt = tlst_pkg::ST_FULL;
          end else if ((count_r != '0) && (key_r < last_time_r)) begin
            out_status_nxt = tlst_pkg::ST_ORDER;
          end else begin
            ram_we         = 1'b1;
            count_nxt      = count_r + CW'(1);
            last_time_nxt  = key_r;
            last_pay_nxt   = pay_r;
            out_status_nxt = tlst_pkg::ST_OK;
            out_time_nxt   = key_r;
            out_pay_nxt    = tlst_pkg::PAY_W'(pay_r);
            out_idx_nxt    = FW'(count_r);
          end
        end
        tlst_pkg::RES_SEEK_OK: begin
          cursor_nxt     = lo_r;
          out_status_nxt = tlst_pkg::ST_OK;
          out_time_nxt   = rd_time;
          out_pay_nxt    = tlst_pkg::PAY_W'(rd_pay);
          out_idx_nxt    = FW'(lo_r);
        end
        tlst_pkg::RES_SEEK_NONE: begin
          cursor_nxt = '0;
        end
        tlst_pkg::RES_NEXT: begin
          cursor_nxt     = cursor_r + CW'(1);
          out_status_nxt = tlst_pkg::ST_OK;
          out_time_nxt   = rd_time;
          out_pay_nxt    = tlst_pkg::PAY_W'(rd_pay);
          out_idx_nxt    = FW'(cursor_r + CW'(1));
        end
        tlst_pkg::RES_PREV: begin
          cursor_nxt     = cursor_r - CW'(1);
          out_status_nxt = tlst_pkg::ST_OK;
          out_more_nxt   = (cursor_r != CW'(1));
          out_time_nxt   = rd_time;
          out_pay_nxt    = tlst_pkg::PAY_W'(rd_pay);
          out_idx_nxt    = FW'(cursor_r - CW'(1));
        end
        tlst_pkg::RES_AT_END: begin
          out_idx_nxt = FW'(cursor_r);
        end
        tlst_pkg::RES_LAST: begin
          if (count_r != '0) begin
            out_status_nxt = tlst_pkg::ST_OK;
            out_time_nxt   = last_time_r;
            out_pay_nxt    = tlst_pkg::PAY_W'(last_pay_r);
            out_idx_nxt    = FW'(count_r - CW'(1));
          end
        end
        tlst_pkg::RES_CLEAR: begin
          count_nxt      = '0;
          cursor_nxt     = '0;
          out_status_nxt = tlst_pkg::ST_OK;
        end
        default: out_status_nxt = tlst_pkg::ST_NONE;
      endcase
      out_cnt_nxt = FW'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    strict_r     <= strict_nxt;
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    last_time_r  <= last_time_nxt;
    last_pay_r   <= last_pay_nxt;
    out_status_r <= out_status_nxt;
    out_more_r   <= out_more_nxt;
    out_time_r   <= out_time_nxt;
    out_pay_r    <= out_pay_nxt;
    out_idx_r    <= out_idx_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_idx_r, out_pay_r, out_time_r};
  assign out_tuser  = {out_more_r, out_status_r};

endmodule

FILE: sv/timestamp_log_seek_table_core.sv
// channel  direction  handshake             payload
// in_      slave      in_tvalid/in_tready   tuser kind, tdata key_time, new_payload
// out_     master     out_tvalid/out_tready tuser status, more;
//                                           tdata entry_time, payload, index, count
//
// Append, read last, clear, unused kinds, next and previous pass through capture, decode and result.
// Seek runs one or two binary searches (the second only when an entry is found),
// one table read per cycle through the single read port, plus decode and result.
// Reset (rst_n low, synchronous) empties the table and zeroes the cursor; no sweep.
// A waiting result sits in the output register; a new transaction is taken meanwhile,
// and its own result waits until that register is free.
module timestamp_log_seek_table_core #(
  parameter int DEPTH         = 1024,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tlst_pkg::IN_TDATA_W-1:0]     in_tdata,   // key_time, new_payload
  input  logic [tlst_pkg::KIND_W-1:0]         in_tuser,   // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tlst_pkg::OUT_TDATA_W-1:0]    out_tdata,  // entry_time, entry_payload,
                                                          // entry_index, entry_count
  output logic [tlst_pkg::OUT_TUSER_W-1:0]    out_tuser   // status, more
);

  tlst_pkg::dp_cmd_t  cmd;
  tlst_pkg::dp_stat_t stat;

  tlst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlst_dp #(.DEPTH(DEPTH), .PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a transaction is in progress");

  a_fail_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[1:0] != tlst_pkg::ST_OK)) |->
      ((out_tdata[63:0] == 64'd0) && (out_tdata[95:64] == 32'd0)))
    else $error("failed operation returned entry data");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");
`endif

endmodule
